FILE: hw/rtl/sdtq_pkg.sv
// Package for the sorted deadline timer queue.
// Holds the transaction payload structs, the FSM state type and the fixed codes.
// No dependencies.
package sdtq_pkg;

  localparam int TagFieldBits = 8;
  localparam int DelayBits    = 31;
  localparam int MaxResults   = 16;

  localparam logic KindSubmit     = 1'b0;
  localparam logic KindTick       = 1'b1;
  localparam logic ResStatus      = 1'b0;
  localparam logic ResCompletion  = 1'b1;
  localparam logic StatusAccepted = 1'b0;
  localparam logic StatusRejected = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [TagFieldBits-1:0] tag;
    logic [DelayBits-1:0]    delay_ticks;
  } in_t;

  typedef struct packed {
    logic                    result_kind;
    logic [TagFieldBits-1:0] result_tag;
    logic                    status;
    logic                    last;
  } out_t;

  typedef enum logic [2:0] {
    StIdle,
    StInsCmp,
    StInsPut,
    StResp,
    StPopCmp,
    StPopEnd
  } state_e;

endpackage

FILE: hw/rtl/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue: sequencer, tick counter and output register.
// Depends on sdtq_pkg and sdtq_ram.
//
// Usage: the input channel carries submit and tick transactions, the output channel
// carries results, both with valid/ready. A submit computes its expiry as the tick
// counter plus the delay and is placed into a circular table kept in expiry order,
// behind all entries with an equal or earlier expiry. It yields one status result
// with last set; a full table rejects it and leaves the state unchanged.
// A tick advances the counter and pops expired entries from the head, at most 16 per
// tick, one completion each, with last on the final one; no expiry means no result.
// An accepted submit into a non-empty table walks from the tail one entry per cycle through
// the one read port and one write port of the table RAM, moving aside each entry with a later
// expiry to open its slot. The block takes one transaction at a time; in_ready_o is high only
// between transactions. When the receiver stalls, the output register holds its result and
// the sequencer waits for it. Reset empties the table and clears the counter at once;
// no clearing pass is needed.
module sorted_deadline_timer_queue
  import sdtq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int TAG_BITS  = 8,
  parameter int TIME_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int TagW = (TAG_BITS < TagFieldBits) ? TAG_BITS : TagFieldBits;
  localparam int EW   = TIME_BITS + TagW;
  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int NW   = $clog2(MaxResults + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LastIdx) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LastIdx : p - AW'(1);
  endfunction

  function automatic logic time_le(input logic [TIME_BITS-1:0] a,
                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d == '0) || d[TIME_BITS-1];
  endfunction

  state_e               state_q, state_d;
  logic [AW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]        count_q, count_d, rem_q, rem_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 have_prev_q, have_prev_d;
  logic                 out_valid_q, out_valid_d;

  logic [AW-1:0]        rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [TIME_BITS-1:0] exp_q, exp_d;
  logic [TagW-1:0]      tag_q, tag_d, prev_tag_q, prev_tag_d;
  logic                 status_q, status_d;
  out_t                 out_q, out_d;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic [TIME_BITS-1:0] r_exp, in_exp;
  logic [TagW-1:0]      r_tag;
  logic                 out_free, in_acc, load;
  out_t                 load_val;

  sdtq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign r_exp    = rdata[EW-1:TagW];
  assign r_tag    = rdata[TagW-1:0];
  assign in_exp   = now_q + TIME_BITS'(in_data_i.delay_ticks);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc   = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    rem_d       = rem_q;
    now_d       = now_q;
    n_d         = n_q;
    have_prev_d = have_prev_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    exp_d       = exp_q;
    tag_d       = tag_q;
    prev_tag_d  = prev_tag_q;
    status_d    = status_q;
    we          = 1'b0;
    waddr       = wr_ptr_q;
    wdata       = {exp_q, tag_q};
    re          = 1'b0;
    raddr       = rd_ptr_q;
    load        = 1'b0;
    load_val    = '{result_kind: ResCompletion,
                    result_tag: TagFieldBits'(prev_tag_q),
                    status: StatusAccepted,
                    last: 1'b0};

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          tag_d = in_data_i.tag[TagW-1:0];
          exp_d = in_exp;
          if (in_data_i.kind == KindSubmit) begin
            if (count_q == CW'(DEPTH)) begin
              status_d = StatusRejected;
              state_d  = StResp;
            end else begin
              status_d = StatusAccepted;
              tail_d   = ptr_inc(tail_q);
              count_d  = count_q + CW'(1);
              if (count_q == '0) begin
                we      = 1'b1;
                waddr   = tail_q;
                wdata   = {in_exp, in_data_i.tag[TagW-1:0]};
                state_d = StResp;
              end else begin
                wr_ptr_d = tail_q;
                rd_ptr_d = ptr_dec(tail_q);
                rem_d    = count_q;
                re       = 1'b1;
                raddr    = ptr_dec(tail_q);
                state_d  = StInsCmp;
              end
            end
          end else begin
            now_d       = now_q + TIME_BITS'(1);
            n_d         = '0;
            have_prev_d = 1'b0;
            if (count_q != '0) begin
              re      = 1'b1;
              raddr   = head_q;
              state_d = StPopCmp;
            end
          end
        end
      end
      StInsCmp: begin
        if (!time_le(r_exp, exp_q)) begin
          we       = 1'b1;
          waddr    = wr_ptr_q;
          wdata    = rdata;
          wr_ptr_d = rd_ptr_q;
          rem_d    = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            state_d = StInsPut;
          end else begin
            rd_ptr_d = ptr_dec(rd_ptr_q);
            re       = 1'b1;
            raddr    = ptr_dec(rd_ptr_q);
          end
        end else begin
          we      = 1'b1;
          state_d = StResp;
        end
      end
      StInsPut: begin
        we      = 1'b1;
        state_d = StResp;
      end
      StResp: begin
        if (out_free) begin
          load     = 1'b1;
          load_val = '{result_kind: ResStatus,
                       result_tag: TagFieldBits'(tag_q),
                       status: status_q,
                       last: 1'b1};
          state_d  = StIdle;
        end
      end
      StPopCmp: begin
        if (!time_le(r_exp, now_q)) begin
          state_d = StPopEnd;
        end else if (!have_prev_q || out_free) begin
          load        = have_prev_q;
          prev_tag_d  = r_tag;
          have_prev_d = 1'b1;
          head_d      = ptr_inc(head_q);
          count_d     = count_q - CW'(1);
          n_d         = n_q + NW'(1);
          if ((n_q != NW'(MaxResults - 1)) && (count_q != CW'(1))) begin
            re    = 1'b1;
            raddr = ptr_inc(head_q);
          end else begin
            state_d = StPopEnd;
          end
        end
      end
      StPopEnd: begin
        if (!have_prev_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          load          = 1'b1;
          load_val.last = 1'b1;
          have_prev_d   = 1'b0;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = load_val;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rem_q       <= '0;
      now_q       <= '0;
      n_q         <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      now_q       <= now_d;
      n_q         <= n_d;
      have_prev_q <= have_prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q   <= rd_ptr_d;
    wr_ptr_q   <= wr_ptr_d;
    exp_q      <= exp_d;
    tag_q      <= tag_d;
    prev_tag_q <= prev_tag_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/sdtq_ram.sv
// Generic simple dual-port RAM for the timer queue: one write port, one read port.
// Read data is registered and holds its value while no read is issued.
// No dependencies.
module sdtq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/sdtq_checker.sv
// Port-level checker for the sorted deadline timer queue, with its bind statement.
// Depends on sdtq_pkg and on the top level's port list.
module sdtq_checker
  import sdtq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == ResStatus |-> out_data_o.last)
    else $error("submit status without last");

  a_completion_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == ResCompletion
      |-> out_data_o.status == StatusAccepted)
    else $error("completion with nonzero status");

  // A submit always has a status result to deliver before the next transaction.
  a_submit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind == KindSubmit |=> !in_ready_o)
    else $error("ready right after a submit");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
